// ===== src/tccs_pkg.sv =====
// shared types, constants and helpers for the text console cursor and scroll block
package tccs_pkg;

   // console layout
   localparam int CONSOLE_COUNT   = 3;
   localparam int VIDEO_MEM_BYTES = 32768;
   localparam int LINE_CELLS      = 80;
   localparam int SCREEN_CELLS    = 2000;
   localparam int REGION_CELLS    = (VIDEO_MEM_BYTES / 2) / CONSOLE_COUNT;

   // field widths
   localparam int CELL_W    = 14;
   localparam int ADDR_W    = 15;
   localparam int BYTE_W    = 8;
   localparam int CON_IN_W  = 3;
   localparam int CON_W     = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 14;

   // reciprocal for the division of a cell offset by the line length
   localparam int LINE_SHIFT = CELL_W + $clog2(LINE_CELLS);
   localparam int LINE_RECIP = ((2 ** LINE_SHIFT) + LINE_CELLS - 1) / LINE_CELLS;
   localparam int RECIP_W    = $clog2(LINE_RECIP + 1);

   // reset values
   localparam logic [BYTE_W-1:0] COLOR_RESET       = 8'd7;
   localparam logic [CELL_W-1:0] BOOT_CURSOR_RESET = 14'd0;

   // character codes
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

   // crtc register indexes
   localparam logic [BYTE_W-1:0] CRTC_START_HI  = 8'h0C;
   localparam logic [BYTE_W-1:0] CRTC_START_LO  = 8'h0D;
   localparam logic [BYTE_W-1:0] CRTC_CURSOR_HI = 8'h0E;
   localparam logic [BYTE_W-1:0] CRTC_CURSOR_LO = 8'h0F;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_COLOR  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_CURSOR = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUT         = 2'd0,
      CMD_SCROLL_UP   = 2'd1,
      CMD_SCROLL_DOWN = 2'd2,
      CMD_SELECT      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_VIDEO      = 2'd0,
      KIND_CRTC_INDEX = 2'd1,
      KIND_CRTC_DATA  = 2'd2
   } kind_type;

   // everything the result side needs to replay one item
   typedef struct packed {
      logic                vid_en;
      logic [CELL_W-1:0]   vid_cell;
      logic [BYTE_W-1:0]   vid_char;
      logic [BYTE_W-1:0]   vid_color;
      logic [COUNT_W-1:0]  count;
      logic [CELL_W-1:0]   cursor;
      logic [CELL_W-1:0]   start;
   } desc_type;

   // one result item
   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
      logic                last;
   } item_type;

   // first cell of a console region
   function automatic logic [CELL_W-1:0] console_base(input logic [CON_W-1:0] c);
      int prod;
      prod = int'(c) * REGION_CELLS;
      return CELL_W'(prod);
   endfunction

endpackage

// ===== src/tccs_core.sv =====
// input register, console state and the per-item cursor and scroll update
module tccs_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tccs_pkg::cmd_type              req_cmd,
   input  logic [tccs_pkg::CON_IN_W-1:0]  req_con,
   input  logic [tccs_pkg::BYTE_W-1:0]    req_char,
   input  logic                           csr_we,
   input  logic [tccs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tccs_pkg::CSR_DAT_W-1:0] csr_data,
   output logic                           desc_valid,
   output tccs_pkg::desc_type             desc,
   input  logic                           desc_ready
);

   localparam int CELL_W = tccs_pkg::CELL_W;
   localparam int END_W  = CELL_W + 1;
   localparam int PROD_W = CELL_W + tccs_pkg::RECIP_W;

   // input register
   logic                          in_valid_ff;
   tccs_pkg::cmd_type             in_cmd_ff;
   logic [tccs_pkg::CON_IN_W-1:0] in_con_ff;
   logic [tccs_pkg::BYTE_W-1:0]   in_char_ff;

   // console state
   logic [CELL_W-1:0]             cursor_ff [tccs_pkg::CONSOLE_COUNT];
   logic [CELL_W-1:0]             start_ff  [tccs_pkg::CONSOLE_COUNT];
   logic [tccs_pkg::CON_W-1:0]    current_ff;
   logic [tccs_pkg::BYTE_W-1:0]   color_ff;

   logic                          con_ok;
   logic [tccs_pkg::CON_W-1:0]    idx;
   logic [CELL_W-1:0]             base;
   logic [END_W-1:0]              end_cell;
   logic [CELL_W-1:0]             cur;
   logic [CELL_W-1:0]             start;
   logic [CELL_W-1:0]             rel;
   logic [PROD_W-1:0]             prod;
   logic [CELL_W-1:0]             line_q;
   logic [CELL_W-1:0]             nl_cur;
   logic                          nl_ok;
   logic                          bs_ok;
   logic                          pr_ok;
   logic                          down_ok;
   logic                          up_ok;
   logic                          is_cur;

   logic [CELL_W-1:0]             cur_in;
   logic [CELL_W-1:0]             start_in;
   logic [tccs_pkg::CON_W-1:0]    current_in;
   logic                          vid_en;
   logic [CELL_W-1:0]             vid_cell;
   logic [tccs_pkg::BYTE_W-1:0]   vid_char;
   logic [1:0]                    flush_n;
   logic [tccs_pkg::COUNT_W-1:0]  count;
   logic                          need_push;
   logic                          fire;

   // selected console and its bounds
   assign con_ok   = int'(in_con_ff) < tccs_pkg::CONSOLE_COUNT;
   assign idx      = con_ok ? in_con_ff[tccs_pkg::CON_W-1:0] : '0;
   assign base     = tccs_pkg::console_base(idx);
   assign end_cell = {1'b0, base} + END_W'(tccs_pkg::REGION_CELLS);
   assign cur      = cursor_ff[idx];
   assign start    = start_ff[idx];
   assign is_cur   = (idx == current_ff);

   // next line start: offset in the region divided by the line length
   assign rel    = (cur >= base) ? (cur - base) : '0;
   assign prod   = PROD_W'(rel) * PROD_W'(tccs_pkg::LINE_RECIP);
   assign line_q = CELL_W'(prod >> tccs_pkg::LINE_SHIFT);
   assign nl_cur = base + CELL_W'((line_q + CELL_W'(1)) * CELL_W'(tccs_pkg::LINE_CELLS));

   // bounds checks
   assign nl_ok   = ({1'b0, cur} + END_W'(2 * tccs_pkg::LINE_CELLS)) < end_cell;
   assign pr_ok   = ({1'b0, cur} + END_W'(tccs_pkg::LINE_CELLS + 1)) < end_cell;
   assign bs_ok   = cur > base;
   assign up_ok   = start > base;
   assign down_ok = ({1'b0, start}
                     + END_W'(tccs_pkg::SCREEN_CELLS + tccs_pkg::LINE_CELLS)) < end_cell;

   // command decode and state update
   always_comb begin
      logic auto_scroll;
      auto_scroll = 1'b0;
      cur_in      = cur;
      start_in    = start;
      current_in  = current_ff;
      vid_en      = 1'b0;
      vid_cell    = cur;
      vid_char    = in_char_ff;
      flush_n     = 2'd0;
      case (in_cmd_ff)
         tccs_pkg::CMD_PUT: begin
            case (in_char_ff)
               tccs_pkg::CH_NEWLINE: begin
                  if (nl_ok) cur_in = nl_cur;
               end
               tccs_pkg::CH_BACKSPACE: begin
                  if (bs_ok) begin
                     cur_in   = cur - CELL_W'(1);
                     vid_en   = 1'b1;
                     vid_cell = cur - CELL_W'(1);
                     vid_char = tccs_pkg::CH_SPACE;
                  end
               end
               default: begin
                  if (pr_ok) begin
                     cur_in = cur + CELL_W'(1);
                     vid_en = 1'b1;
                  end
               end
            endcase
            // cursor below the visible screen scrolls one line down
            auto_scroll = {1'b0, cur_in} >= ({1'b0, start} + END_W'(tccs_pkg::SCREEN_CELLS));
            if (auto_scroll && down_ok) start_in = start + CELL_W'(tccs_pkg::LINE_CELLS);
            if (is_cur) flush_n = auto_scroll ? 2'd2 : 2'd1;
         end
         tccs_pkg::CMD_SCROLL_UP: begin
            if (up_ok) start_in = start - CELL_W'(tccs_pkg::LINE_CELLS);
            if (is_cur) flush_n = 2'd1;
         end
         tccs_pkg::CMD_SCROLL_DOWN: begin
            if (down_ok) start_in = start + CELL_W'(tccs_pkg::LINE_CELLS);
            if (is_cur) flush_n = 2'd1;
         end
         default: begin
            current_in = idx;
            flush_n    = 2'd1;
         end
      endcase
   end

   // result count: two video bytes, eight port writes per flush
   assign count = (vid_en ? tccs_pkg::COUNT_W'(2) : '0)
                  + (tccs_pkg::COUNT_W'(flush_n) << 3);

   assign need_push  = con_ok && (count != '0);
   assign fire       = in_valid_ff && (desc_ready || !need_push);
   assign req_ready  = !in_valid_ff || fire;
   assign desc_valid = fire && need_push;

   // descriptor for the result side
   always_comb begin
      desc.vid_en    = vid_en;
      desc.vid_cell  = vid_cell;
      desc.vid_char  = vid_char;
      desc.vid_color = color_ff;
      desc.count     = count;
      desc.cursor    = cur_in;
      desc.start     = start_in;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_cmd_ff  <= req_cmd;
         in_con_ff  <= req_con;
         in_char_ff <= req_char;
      end
   end

   // console state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         // console zero starts at the boot cursor, the others at their region start
         for (int i = 0; i < tccs_pkg::CONSOLE_COUNT; i++) begin
            cursor_ff[i] <= (i == 0) ? tccs_pkg::BOOT_CURSOR_RESET
                                     : tccs_pkg::console_base(tccs_pkg::CON_W'(i));
            start_ff[i]  <= tccs_pkg::console_base(tccs_pkg::CON_W'(i));
         end
         current_ff   <= '0;
         color_ff     <= tccs_pkg::COLOR_RESET;
      end else begin
         if (fire && con_ok) begin
            cursor_ff[idx] <= cur_in;
            start_ff[idx]  <= start_in;
            current_ff     <= current_in;
         end
         if (csr_we) begin
            case (csr_index)
               tccs_pkg::CSR_CHAR_COLOR:  color_ff     <= csr_data[tccs_pkg::BYTE_W-1:0];
               tccs_pkg::CSR_BOOT_CURSOR: cursor_ff[0] <= csr_data[CELL_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== src/tccs_serializer.sv =====
// two-entry descriptor queue that plays out each item's results one per cycle while item_ready is high
module tccs_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                desc_valid,
   input  tccs_pkg::desc_type  desc,
   output logic                desc_ready,
   output logic                item_valid,
   output tccs_pkg::item_type  item,
   input  logic                item_ready
);

   localparam int COUNT_W = tccs_pkg::COUNT_W;

   logic                      pend_valid_ff;
   tccs_pkg::desc_type        pend_ff;
   logic                      act_valid_ff;
   tccs_pkg::desc_type        act_ff;
   logic [COUNT_W-1:0]        pos_ff;

   logic                      step;
   logic                      gen_last;
   logic                      load;
   logic [COUNT_W-1:0]        off;
   logic [COUNT_W-1:0]        k;
   logic [tccs_pkg::CELL_W-1:0] value;

   assign desc_ready = !pend_valid_ff;
   assign item_valid = act_valid_ff;
   assign step       = act_valid_ff && item_ready;
   assign gen_last   = pos_ff == (act_ff.count - COUNT_W'(1));
   assign load       = pend_valid_ff && (!act_valid_ff || (step && gen_last));

   // position within the port-write part of the sequence
   assign off   = act_ff.vid_en ? COUNT_W'(2) : '0;
   assign k     = pos_ff - off;
   assign value = k[2] ? act_ff.start : act_ff.cursor;

   // result at the current position
   always_comb begin
      item.last = gen_last;
      if (act_ff.vid_en && (pos_ff < COUNT_W'(2))) begin
         item.kind = tccs_pkg::KIND_VIDEO;
         item.addr = {act_ff.vid_cell, pos_ff[0]};
         item.data = pos_ff[0] ? act_ff.vid_color : act_ff.vid_char;
      end else begin
         item.addr = '0;
         if (k[0]) begin
            item.kind = tccs_pkg::KIND_CRTC_DATA;
            item.data = k[1] ? value[7:0] : {2'b00, value[tccs_pkg::CELL_W-1:8]};
         end else begin
            item.kind = tccs_pkg::KIND_CRTC_INDEX;
            if (k[2]) item.data = k[1] ? tccs_pkg::CRTC_START_LO : tccs_pkg::CRTC_START_HI;
            else      item.data = k[1] ? tccs_pkg::CRTC_CURSOR_LO : tccs_pkg::CRTC_CURSOR_HI;
         end
      end
   end

   // queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         act_valid_ff  <= 1'b0;
         pos_ff        <= '0;
      end else begin
         if (load) begin
            pend_valid_ff <= 1'b0;
         end else if (desc_valid) begin
            pend_valid_ff <= 1'b1;
         end
         if (load) begin
            act_valid_ff <= 1'b1;
            pos_ff       <= '0;
         end else if (step) begin
            if (gen_last) act_valid_ff <= 1'b0;
            pos_ff <= pos_ff + COUNT_W'(1);
         end
      end
   end

   // descriptor payloads
   always_ff @(posedge clock) begin
      if (desc_valid && desc_ready) pend_ff <= desc;
      if (load)                     act_ff  <= pend_ff;
   end

`ifndef SYNTHESIS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      desc_valid |-> !pend_valid_ff)
      else $error("descriptor pushed into a full slot");
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      act_valid_ff |-> (pos_ff < act_ff.count))
      else $error("result position past the item's count");
   a_no_empty_desc: assert property (@(posedge clock) disable iff (reset)
      act_valid_ff |-> (act_ff.count != '0))
      else $error("active descriptor has no results");
   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (step && gen_last && !pend_valid_ff) |=> !act_valid_ff)
      else $error("active slot still busy after its last result");
`endif

endmodule

// ===== src/text_console_cursor_scroll.sv =====
// top level of the multi-console text cursor, scroll and crtc update block
// items pass the input register, descriptor queue and output register to the result port
// one result per cycle while rsp_tready is high; each item gives zero to eighteen results
// input register and two-entry queue take items back to back while the queue has room
// synchronous active-high reset: consoles at their region start, console zero at boot cursor
module text_console_cursor_scroll (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,  // console_index, char_code, zero pad
   input  logic [1:0]                     req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,  // out_addr, out_data, zero pad
   output logic [1:0]                     rsp_tuser,  // out_kind
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [tccs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tccs_pkg::CSR_DAT_W-1:0] csr_data
);

   logic                  desc_valid;
   tccs_pkg::desc_type    desc;
   logic                  desc_ready;
   logic                  item_valid;
   tccs_pkg::item_type    item;
   logic                  item_ready;

   logic                  rsp_valid_ff;
   tccs_pkg::item_type    rsp_item_ff;

   tccs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (tccs_pkg::cmd_type'(req_tuser)),
      .req_con    (req_tdata[2:0]),
      .req_char   (req_tdata[10:3]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_ready (desc_ready)
   );

   tccs_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_ready (desc_ready),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   // output register
   assign item_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_ready) begin
         rsp_valid_ff <= item_valid;
      end
      if (item_ready && item_valid) rsp_item_ff <= item;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_item_ff.data, rsp_item_ff.addr};
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tlast  = rsp_item_ff.last;

endmodule
